// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/i2cseq_pkg.sv -----
// ---------------------------------------------------------------------------
// i2cseq_pkg
// Transaction types, codes and state layout of the I2C master sequencer.
// ---------------------------------------------------------------------------
package i2cseq_pkg;

  localparam int CNT_W = 6;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // start kinds
  localparam logic [1:0] MODE_WRITE    = 2'd0;
  localparam logic [1:0] MODE_READ     = 2'd1;
  localparam logic [1:0] MODE_WR_RD    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // classified bus status
  localparam logic [3:0] ST_START     = 4'd0;
  localparam logic [3:0] ST_REP_START = 4'd1;
  localparam logic [3:0] ST_SLAW_ACK  = 4'd2;
  localparam logic [3:0] ST_DATA_ACK  = 4'd3;
  localparam logic [3:0] ST_RX_ACK    = 4'd4;
  localparam logic [3:0] ST_SLAR_ACK  = 4'd5;
  localparam logic [3:0] ST_RX_NACK   = 4'd6;

  // bus commands
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_SEND    = 3'd3;
  localparam logic [2:0] CMD_RX_ACK  = 3'd4;
  localparam logic [2:0] CMD_RX_NACK = 3'd5;
  localparam logic [2:0] CMD_RETRY   = 3'd6;

  localparam logic DIR_READ  = 1'b1;
  localparam logic DIR_WRITE = 1'b0;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] tx_index;
    logic [7:0] tx_data;
    logic [1:0] mode;
    logic [6:0] slave_address;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [3:0] bus_status;
    logic [7:0] rx_data;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [4:0] rx_index;
    logic [7:0] rx_byte;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic             busy;
    logic [1:0]       kind;
    logic             reading;
    logic [6:0]       address;
    logic [CNT_W-1:0] to_write;
    logic [CNT_W-1:0] to_read;
    logic [CNT_W-1:0] position;
  } seq_state_t;

endpackage

// ----- rtl/i2cseq_ram.sv -----
// ---------------------------------------------------------------------------
// i2cseq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module i2cseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/i2cseq_step.sv -----
// ---------------------------------------------------------------------------
// i2cseq_step
// Sequencer decision logic: one transaction in, next state and result out.
// ---------------------------------------------------------------------------
module i2cseq_step #(
  parameter int DEPTH = 32
) (
  input  i2cseq_pkg::seq_state_t state,
  input  i2cseq_pkg::item_t      item,
  input  logic [7:0]             store_byte,
  output i2cseq_pkg::seq_state_t state_next,
  output i2cseq_pkg::result_t    res
);

  localparam logic [i2cseq_pkg::CNT_W-1:0] DEPTH_C = i2cseq_pkg::CNT_W'(DEPTH);
  localparam logic [7:0] DEPTH_B = 8'(DEPTH);

  logic [i2cseq_pkg::CNT_W-1:0] pos_new;
  logic                         pos_room;

  assign pos_room = state.position < DEPTH_C;

  always_comb begin
    state_next      = state;
    res             = '0;
    res.bus_command = i2cseq_pkg::CMD_NONE;
    pos_new         = state.position;
    case (item.operation)
      i2cseq_pkg::OP_START: begin
        if (item.mode != i2cseq_pkg::MODE_RESERVED) begin
          state_next.busy     = 1'b1;
          state_next.kind     = item.mode;
          state_next.reading  = (item.mode == i2cseq_pkg::MODE_READ);
          state_next.address  = item.slave_address;
          state_next.to_write = (item.write_count > DEPTH_B) ? DEPTH_C :
                                i2cseq_pkg::CNT_W'(item.write_count);
          state_next.to_read  = (item.read_count > DEPTH_B) ? DEPTH_C :
                                i2cseq_pkg::CNT_W'(item.read_count);
          if (item.read_count == 8'd0) begin
            state_next.to_read = i2cseq_pkg::CNT_W'(1);
          end
          res.bus_command = i2cseq_pkg::CMD_START;
        end
      end
      i2cseq_pkg::OP_EVENT: begin
        case (item.bus_status)
          i2cseq_pkg::ST_START, i2cseq_pkg::ST_REP_START: begin
            state_next.position = '0;
            res.tx_byte = {state.address,
                           state.reading ? i2cseq_pkg::DIR_READ : i2cseq_pkg::DIR_WRITE};
            res.bus_command = i2cseq_pkg::CMD_SEND;
          end
          i2cseq_pkg::ST_SLAW_ACK, i2cseq_pkg::ST_DATA_ACK: begin
            if (state.position >= state.to_write) begin
              // end of write phase: turn around or finish
              if (state.kind == i2cseq_pkg::MODE_WR_RD) begin
                state_next.reading = 1'b1;
                res.bus_command    = i2cseq_pkg::CMD_START;
              end else begin
                state_next.busy = 1'b0;
                res.bus_command = i2cseq_pkg::CMD_STOP;
              end
            end else begin
              res.tx_byte         = store_byte;
              state_next.position = state.position + 1'b1;
              res.bus_command     = i2cseq_pkg::CMD_SEND;
            end
          end
          i2cseq_pkg::ST_RX_ACK, i2cseq_pkg::ST_SLAR_ACK: begin
            if (item.bus_status == i2cseq_pkg::ST_RX_ACK && pos_room) begin
              res.rx_valid = 1'b1;
              res.rx_index = 5'(state.position);
              res.rx_byte  = item.rx_data;
              pos_new      = state.position + 1'b1;
            end
            state_next.position = pos_new;
            // NACK the byte that will be the last one
            res.bus_command = ({1'b0, pos_new} + 1'b1 == {1'b0, state.to_read}) ?
                              i2cseq_pkg::CMD_RX_NACK : i2cseq_pkg::CMD_RX_ACK;
          end
          i2cseq_pkg::ST_RX_NACK: begin
            if (pos_room) begin
              res.rx_valid        = 1'b1;
              res.rx_index        = 5'(state.position);
              res.rx_byte         = item.rx_data;
              state_next.position = state.position + 1'b1;
            end
            state_next.busy = 1'b0;
            res.bus_command = i2cseq_pkg::CMD_STOP;
          end
          default: begin
            res.bus_command = i2cseq_pkg::CMD_RETRY;
          end
        endcase
      end
      default: begin
        res.bus_command = i2cseq_pkg::CMD_NONE;
      end
    endcase
    res.busy_res = state_next.busy;
  end

endmodule

// ----- rtl/i2c_master_transaction_sequencer.sv -----
// ---------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// I2C master sequencer: transmit buffer loads, transaction starts and
// classified bus events in, one bus command per transaction out.
// ---------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid, item_stall, item) takes loads, starts and
//   bus status events. Every transaction produces exactly one result on the
//   result channel (result_valid, result_stall, result) carrying the next
//   bus command, the byte to send, any received byte with its index, and
//   the busy flag after the transaction.
//   A transaction is accepted into one input register and its result is
//   loaded into one result register, with the decision logic between them,
//   raising result_valid. One transaction is accepted every cycle while the
//   result side keeps taking.
//   The transmit buffer is a RAM with registered read data, read ahead at
//   the next byte position; a load to that position is forwarded around the RAM.
//   When result_stall is high the result register holds and one more
//   transaction is taken into the input register; item_stall rises only
//   when both registers are full.
//   Reset clears the sequencer state and both valid flags. The transmit
//   buffer is not cleared: send only slots that were loaded.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_transaction_sequencer #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  i2cseq_pkg::item_t     item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output i2cseq_pkg::result_t   result
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [i2cseq_pkg::CNT_W-1:0] DEPTH_C =
    i2cseq_pkg::CNT_W'(BUFFER_DEPTH);

  logic                   s1_valid;
  i2cseq_pkg::item_t      s1_item;
  logic                   res_free;
  logic                   process;
  i2cseq_pkg::seq_state_t state;
  i2cseq_pkg::seq_state_t state_next;
  i2cseq_pkg::result_t    step_res;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [i2cseq_pkg::CNT_W-1:0] rpos;
  logic [7:0]             ram_rdata;
  logic                   bypass;
  logic [7:0]             bypass_data;
  logic [7:0]             store_byte;

  assign res_free   = !result_valid || !result_stall;
  assign process    = s1_valid && res_free;
  assign item_stall = s1_valid && !res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_free) begin
      result_valid <= s1_valid;
    end
    if (process) begin
      result <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (process) begin
      state <= state_next;
    end
  end

  // read ahead at the position the next transaction will see
  assign rpos  = process ? state_next.position : state.position;
  assign raddr = (rpos < DEPTH_C) ? AW'(rpos) : '0;
  assign we    = process && (s1_item.operation == i2cseq_pkg::OP_LOAD) &&
                 (i2cseq_pkg::CNT_W'(s1_item.tx_index) < DEPTH_C);
  assign waddr = AW'(s1_item.tx_index);

  i2cseq_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(s1_item.tx_data),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // forward a load that hits the slot being read
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else begin
      bypass <= we && (waddr == raddr);
    end
    bypass_data <= s1_item.tx_data;
  end

  assign store_byte = bypass ? bypass_data : ram_rdata;

  i2cseq_step #(
    .DEPTH(BUFFER_DEPTH)
  ) u_step (
    .state     (state),
    .item      (s1_item),
    .store_byte(store_byte),
    .state_next(state_next),
    .res       (step_res)
  );

  `ASSERT_IMPLIES(a_stall_only_when_full, item_stall, s1_valid && result_valid)
  `ASSERT_IMPLIES(a_stop_clears_busy,
    result_valid && result.bus_command == i2cseq_pkg::CMD_STOP, !result.busy_res)
  `ASSERT_IMPLIES(a_rx_with_receive_cmd, result_valid && result.rx_valid,
    result.bus_command == i2cseq_pkg::CMD_RX_ACK ||
    result.bus_command == i2cseq_pkg::CMD_RX_NACK ||
    result.bus_command == i2cseq_pkg::CMD_STOP)
  `ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)

endmodule

// ----- dv/tb_i2c_master_transaction_sequencer.sv -----
// ---------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer
// Self-checking bench for the I2C master sequencer. A local predictor tracks
// the transfer state and transmit buffer, computes the bus response for
// every accepted transaction, and a monitor compares each returned response
// field by field. Directed cases cover idle events, each transfer kind,
// retries, receive overflow and one long result hold-off; random well-formed
// transfers with injected noise follow, under random idling.
// ---------------------------------------------------------------------------
module tb_i2c_master_transaction_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;

  localparam int         BUFFER_DEPTH   = 32;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         RANDOM_ITEMS   = 700;
  localparam int         DRAIN_CYCLES   = 10;
  localparam logic [1:0] OP_RESERVED    = 2'd3;
  localparam logic [3:0] ST_DATA_NACK   = 4'd7;
  localparam logic [3:0] ST_SLAR_NACK   = 4'd8;
  localparam logic [3:0] ST_ARB_LOST    = 4'd9;
  localparam logic [3:0] ST_OTHER       = 4'd10;
  localparam logic [3:0] ST_UNDEFINED   = 4'd15;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // predictor state
  logic                 seq_busy = 1'b0;
  logic [1:0]           seq_kind = '0;
  logic                 seq_reading = 1'b0;
  logic [6:0]           seq_addr = '0;
  logic [CNT_W-1:0]     seq_to_write = '0;
  logic [CNT_W-1:0]     seq_to_read = '0;
  logic [CNT_W-1:0]     seq_pos = '0;
  logic [7:0]           tx_store [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] tx_written = '0;

  result_t pending_responses[$];
  result_t want;
  int      check_errors = 0;
  int      items_sent = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  bit      send_idle = 1'b1;
  bit      recv_idle = 1'b1;

  i2c_master_transaction_sequencer #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] clamp_count(input logic [7:0] n);
    return (n > BUFFER_DEPTH) ? CNT_W'(BUFFER_DEPTH) : CNT_W'(n);
  endfunction

  // Advance the predictor by one transaction and return the bus response.
  function automatic result_t next_bus_response(input item_t it);
    result_t r;
    r = '0;
    r.bus_command = CMD_NONE;
    case (it.operation)
      OP_LOAD: begin
        tx_store[it.tx_index] = it.tx_data;
        tx_written[it.tx_index] = 1'b1;
      end
      OP_START: begin
        if (it.mode != MODE_RESERVED) begin
          seq_busy = 1'b1;
          seq_kind = it.mode;
          seq_reading = (it.mode == MODE_READ);
          seq_addr = it.slave_address;
          seq_to_write = clamp_count(it.write_count);
          seq_to_read = clamp_count(it.read_count);
          if (seq_to_read == '0) seq_to_read = CNT_W'(1);
          r.bus_command = CMD_START;
        end
      end
      OP_EVENT: begin
        case (it.bus_status)
          ST_START, ST_REP_START: begin
            seq_pos = '0;
            r.tx_byte = {seq_addr, seq_reading ? DIR_READ : DIR_WRITE};
            r.bus_command = CMD_SEND;
          end
          ST_SLAW_ACK, ST_DATA_ACK: begin
            if (seq_pos >= seq_to_write) begin
              // write phase done: turn around or finish
              if (seq_kind == MODE_WR_RD) begin
                seq_reading = 1'b1;
                r.bus_command = CMD_START;
              end else begin
                seq_busy = 1'b0;
                r.bus_command = CMD_STOP;
              end
            end else begin
              r.tx_byte = tx_store[seq_pos[4:0]];
              seq_pos = seq_pos + 1'b1;
              r.bus_command = CMD_SEND;
            end
          end
          ST_RX_ACK, ST_SLAR_ACK: begin
            if (it.bus_status == ST_RX_ACK && seq_pos < BUFFER_DEPTH) begin
              r.rx_valid = 1'b1;
              r.rx_index = seq_pos[4:0];
              r.rx_byte = it.rx_data;
              seq_pos = seq_pos + 1'b1;
            end
            r.bus_command = (seq_pos + 1 == seq_to_read) ? CMD_RX_NACK : CMD_RX_ACK;
          end
          ST_RX_NACK: begin
            if (seq_pos < BUFFER_DEPTH) begin
              r.rx_valid = 1'b1;
              r.rx_index = seq_pos[4:0];
              r.rx_byte = it.rx_data;
              seq_pos = seq_pos + 1'b1;
            end
            seq_busy = 1'b0;
            r.bus_command = CMD_STOP;
          end
          default: r.bus_command = CMD_RETRY;
        endcase
      end
      default: ;
    endcase
    r.busy_res = seq_busy;
    return r;
  endfunction

  function automatic item_t random_item();
    logic [$bits(item_t)-1:0] raw;
    raw = $bits(item_t)'({$urandom, $urandom});
    return raw;
  endfunction

  function automatic item_t make_load(input logic [4:0] idx, input logic [7:0] data);
    item_t it;
    it = random_item();
    it.operation = OP_LOAD;
    it.tx_index = idx;
    it.tx_data = data;
    return it;
  endfunction

  function automatic item_t make_start(input logic [1:0] mode, input logic [6:0] addr,
                                       input logic [7:0] wr_count,
                                       input logic [7:0] rd_count);
    item_t it;
    it = random_item();
    it.operation = OP_START;
    it.mode = mode;
    it.slave_address = addr;
    it.write_count = wr_count;
    it.read_count = rd_count;
    return it;
  endfunction

  function automatic item_t make_event(input logic [3:0] status, input logic [7:0] rx);
    item_t it;
    it = random_item();
    it.operation = OP_EVENT;
    it.bus_status = status;
    it.rx_data = rx;
    return it;
  endfunction

  // Present one transaction and hold it until accepted.
  task automatic push_item(input item_t it);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    pending_responses.push_back(next_bus_response(it));
    items_sent++;
  endtask

  // Load the buffer slot first when this event would send an unloaded byte.
  task automatic send_item(input item_t it);
    if (it.operation == OP_EVENT &&
        (it.bus_status == ST_SLAW_ACK || it.bus_status == ST_DATA_ACK) &&
        seq_pos < seq_to_write && !tx_written[seq_pos[4:0]]) begin
      push_item(make_load(seq_pos[4:0], 8'($urandom_range(0, 255))));
    end
    push_item(it);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      check_errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      stall_left = recv_idle ? $urandom_range(0, 9) : 0;
      if (pending_responses.size() == 0) begin
        check_errors++;
        $display("%0t: unexpected response: expected none, actual %p", $time, result);
      end else begin
        want = pending_responses.pop_front();
        check_field("bus_command", 8'(want.bus_command), 8'(result.bus_command));
        check_field("tx_byte", want.tx_byte, result.tx_byte);
        check_field("rx_valid", 8'(want.rx_valid), 8'(result.rx_valid));
        check_field("rx_index", 8'(want.rx_index), 8'(result.rx_index));
        check_field("rx_byte", want.rx_byte, result.rx_byte);
        check_field("busy_res", 8'(want.busy_res), 8'(result.busy_res));
      end
    end
  end

  // result side stall: long hold-off first, then per-response idling
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_idle_events();
    send_item(make_event(ST_START, 8'h00));
    send_item(make_event(ST_SLAW_ACK, 8'hFF));
    send_item(make_event(ST_RX_ACK, 8'hFF));
    send_item(make_event(ST_RX_NACK, 8'h00));
    begin
      item_t it;
      it = random_item();
      it.operation = OP_RESERVED;
      send_item(it);
    end
    send_item(make_start(MODE_RESERVED, 7'h7F, 8'hFF, 8'hFF));
  endtask

  task automatic test_write_only();
    send_item(make_load(5'd0, 8'h00));
    send_item(make_load(5'd1, 8'hFF));
    send_item(make_load(5'd31, 8'hA5));
    send_item(make_start(MODE_WRITE, 7'h7F, 8'd2, 8'd0));
    send_item(make_event(ST_START, 8'h00));
    send_item(make_event(ST_SLAW_ACK, 8'h00));
    send_item(make_event(ST_DATA_ACK, 8'h00));
    send_item(make_event(ST_DATA_ACK, 8'h00));
  endtask

  task automatic test_write_then_read();
    send_item(make_start(MODE_WR_RD, 7'h00, 8'd1, 8'd2));
    send_item(make_event(ST_START, 8'h00));
    send_item(make_event(ST_SLAW_ACK, 8'h00));
    send_item(make_event(ST_DATA_ACK, 8'h00));
    send_item(make_event(ST_REP_START, 8'h00));
    send_item(make_event(ST_SLAR_ACK, 8'h00));
    send_item(make_event(ST_RX_ACK, 8'hFF));
    send_item(make_event(ST_RX_NACK, 8'h00));
  endtask

  task automatic test_read_zero_count();
    send_item(make_start(MODE_READ, 7'h2A, 8'd255, 8'd0));
    send_item(make_event(ST_START, 8'h00));
    send_item(make_event(ST_SLAR_ACK, 8'h00));
    send_item(make_event(ST_RX_NACK, 8'h5A));
  endtask

  // Error statuses retry; a start while busy replaces the transfer.
  task automatic test_retry_and_restart();
    send_item(make_start(MODE_WRITE, 7'h11, 8'd3, 8'd1));
    send_item(make_event(ST_DATA_NACK, 8'h00));
    send_item(make_event(ST_SLAR_NACK, 8'h00));
    send_item(make_event(ST_ARB_LOST, 8'h00));
    send_item(make_event(ST_OTHER, 8'h00));
    send_item(make_event(ST_UNDEFINED, 8'h00));
    send_item(make_start(MODE_READ, 7'h22, 8'd0, 8'd1));
    send_item(make_event(ST_RX_NACK, 8'h3C));
  endtask

  // Read more bytes than the buffer holds: extra bytes are dropped.
  task automatic test_receive_overflow();
    send_item(make_start(MODE_READ, 7'h40, 8'd0, 8'd255));
    send_item(make_event(ST_START, 8'h00));
    send_item(make_event(ST_SLAR_ACK, 8'h00));
    repeat (BUFFER_DEPTH + 2)
      send_item(make_event(ST_RX_ACK, 8'($urandom_range(0, 255))));
    send_item(make_event(ST_RX_NACK, 8'hFF));
  endtask

  // Hold off the result side while transactions keep coming in.
  task automatic test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_left = 80;
    send_item(make_start(MODE_WRITE, 7'h5A, 8'd6, 8'd0));
    send_item(make_event(ST_START, 8'h00));
    send_item(make_event(ST_SLAW_ACK, 8'h00));
    repeat (6) send_item(make_event(ST_DATA_ACK, 8'h00));
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  function automatic logic [7:0] pick_count();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 5));
  endfunction

  // Send the scripted status, sometimes replaced by noise.
  task automatic send_event(input logic [3:0] status);
    if ($urandom_range(0, 9) == 0)
      send_item(make_load(seq_pos[4:0], 8'($urandom_range(0, 255))));
    if ($urandom_range(0, 19) == 0)
      send_item(random_item());
    else if ($urandom_range(0, 19) == 0)
      send_item(make_event(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
    else
      send_item(make_event(status, 8'($urandom_range(0, 255))));
  endtask

  task automatic test_random_transfers();
    int          stop_at;
    logic [1:0]  mode;
    logic [7:0]  wr_count;
    logic [7:0]  rd_count;
    int          n_write;
    int          n_read;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      mode = 2'($urandom_range(0, 2));
      wr_count = pick_count();
      rd_count = pick_count();
      n_write = int'(clamp_count(wr_count));
      n_read = (rd_count == 0) ? 1 : int'(clamp_count(rd_count));
      repeat ($urandom_range(0, 3))
        send_item(make_load(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255))));
      send_item(make_start(mode, 7'($urandom_range(0, 127)), wr_count, rd_count));
      send_event(ST_START);
      if (mode != MODE_READ) begin
        send_event(ST_SLAW_ACK);
        repeat (n_write) send_event(ST_DATA_ACK);
        if (mode == MODE_WR_RD) send_event(ST_REP_START);
      end
      if (mode != MODE_WRITE) begin
        send_event(ST_SLAR_ACK);
        // occasionally overrun the count to reach the receive overflow
        repeat (n_read - 1 + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0))
          send_event(ST_RX_ACK);
        send_event(ST_RX_NACK);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_events();
    test_write_only();
    test_write_then_read();
    test_read_zero_count();
    test_retry_and_restart();
    test_receive_overflow();
    test_backpressure();
    test_random_transfers();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_errors == 0 && pending_responses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/i2cseq_pkg.sv
rtl/i2cseq_ram.sv
rtl/i2cseq_step.sv
rtl/i2c_master_transaction_sequencer.sv
dv/tb_i2c_master_transaction_sequencer.sv
